>>> sv/seek_index_cue_lookup_unit_macros.svh
// assertion macros for the seek index cue lookup unit
`ifndef SEEK_INDEX_CUE_LOOKUP_UNIT_MACROS_SVH
`define SEEK_INDEX_CUE_LOOKUP_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SICL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SICL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sicl_pkg.sv
// shared types and constants of the seek index cue lookup unit
package sicl_pkg;

   localparam int unsigned DATA_W      = 64;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned REQ_TDATA_W = 200;
   localparam int unsigned RSP_FIELD_W = 1 + 2 * DATA_W;
   localparam int unsigned RSP_TDATA_W = 136;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REPLACED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic scan_step;
      logic commit;
      logic shift_step;
      logic place;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic decided;
      logic need_shift;
      logic shift_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/sicl_ctrl.sv
// controller state machine: sequences scan, shift and result hand-off
module sicl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sicl_pkg::dp_status_type dp_status,
   output sicl_pkg::cmd_type       cmd
);

   sicl_pkg::state_type state_ff;
   sicl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sicl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sicl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = sicl_pkg::ST_SCAN;
            end
         end
         sicl_pkg::ST_SCAN: begin
            if (dp_status.decided) begin
               cmd.commit = 1'b1;
               state_in   = dp_status.need_shift ? sicl_pkg::ST_SHIFT : sicl_pkg::ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         sicl_pkg::ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (dp_status.shift_done) begin
               cmd.place = 1'b1;
               state_in  = sicl_pkg::ST_FINISH;
            end
         end
         sicl_pkg::ST_FINISH: begin
            if (dp_status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sicl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sicl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/sicl_dp.sv
// datapath: cue memories, scan compare, shift pipeline and result register
module sicl_dp #(
   parameter int unsigned MAX_CUES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sicl_pkg::cmd_type                 cmd,
   output sicl_pkg::dp_status_type           dp_status,
   input  logic                              mode,
   input  logic [sicl_pkg::DATA_W-1:0]       key_time,
   input  logic [sicl_pkg::DATA_W-1:0]       now_time,
   input  logic                              forward,
   input  logic [sicl_pkg::DATA_W-1:0]       position_in,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [sicl_pkg::STATUS_W-1:0]     status,
   output logic                              found,
   output logic [sicl_pkg::DATA_W-1:0]       hit_time,
   output logic [sicl_pkg::DATA_W-1:0]       position_out
);

   localparam int unsigned CNT_W = $clog2(MAX_CUES + 1);
   localparam int unsigned AW    = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CUES);

   logic [sicl_pkg::DATA_W-1:0] time_mem [MAX_CUES];
   logic [sicl_pkg::DATA_W-1:0] pos_mem  [MAX_CUES];

   logic                          mode_ff;
   logic [sicl_pkg::DATA_W-1:0]   key_ff;
   logic [sicl_pkg::DATA_W-1:0]   now_ff;
   logic                          fwd_ff;
   logic [sicl_pkg::DATA_W-1:0]   pos_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              idx_ff;
   logic [CNT_W-1:0]              slot_ff;
   logic [CNT_W-1:0]              rd_idx_ff;
   logic                          rd_vld_ff;
   logic [sicl_pkg::DATA_W-1:0]   rd_time_ff;
   logic [sicl_pkg::DATA_W-1:0]   rd_pos_ff;
   logic [sicl_pkg::DATA_W-1:0]   sel_time_ff;
   logic [sicl_pkg::DATA_W-1:0]   sel_pos_ff;
   logic                          sel_found_ff;
   logic [sicl_pkg::STATUS_W-1:0] status_ff;
   logic                          out_valid_ff;
   logic [sicl_pkg::STATUS_W-1:0] out_status_ff;
   logic                          out_found_ff;
   logic [sicl_pkg::DATA_W-1:0]   out_time_ff;
   logic [sicl_pkg::DATA_W-1:0]   out_pos_ff;

   logic             cur_eq, cur_gt, cur_ge, cur_ok, prev_ok;
   logic             pick_cur, pick_prev, hit, scan_end, replace, full;
   logic             is_query, scan_issue, shift_issue, rd_en;
   logic [CNT_W-1:0] rd_addr, shift_wa;
   logic             time_we, pos_we;
   logic [CNT_W-1:0] time_wa, pos_wa;
   logic [sicl_pkg::DATA_W-1:0] time_wd, pos_wd;

   // scan decision on the entry read last cycle
   always_comb begin
      is_query  = (mode_ff == sicl_pkg::MODE_QUERY);
      cur_eq    = (rd_time_ff == key_ff);
      cur_gt    = (rd_time_ff > key_ff);
      cur_ge    = cur_eq || cur_gt;
      cur_ok    = !fwd_ff || (now_ff < rd_time_ff);
      prev_ok   = !fwd_ff || (now_ff < sel_time_ff);
      pick_cur  = (cur_eq && cur_ok) || (cur_gt && !sel_found_ff);
      pick_prev = cur_gt && sel_found_ff && prev_ok;
      hit       = rd_vld_ff && (is_query ? (pick_cur || pick_prev) : cur_ge);
      scan_end  = !rd_vld_ff && (idx_ff == count_ff);
      replace   = !is_query && hit && cur_eq;
      full      = (count_ff == MAX_COUNT);

      scan_issue  = (idx_ff < count_ff);
      shift_issue = (idx_ff > slot_ff);
      rd_en       = (cmd.scan_step && scan_issue) || (cmd.shift_step && shift_issue);
      rd_addr     = cmd.scan_step ? idx_ff : (idx_ff - CNT_W'(1));
      shift_wa    = rd_idx_ff + CNT_W'(1);

      dp_status.decided    = hit || scan_end;
      dp_status.need_shift = !is_query && !replace && !full;
      dp_status.shift_done = !rd_vld_ff && !shift_issue;
      dp_status.out_free   = !out_valid_ff || rsp_tready;
   end

   // write port select
   always_comb begin
      time_we = 1'b0;
      time_wa = shift_wa;
      time_wd = rd_time_ff;
      pos_we  = 1'b0;
      pos_wa  = shift_wa;
      pos_wd  = rd_pos_ff;
      priority if (cmd.place) begin
         time_we = 1'b1;
         time_wa = slot_ff;
         time_wd = key_ff;
         pos_we  = 1'b1;
         pos_wa  = slot_ff;
         pos_wd  = pos_ff;
      end else if (cmd.shift_step && rd_vld_ff) begin
         time_we = 1'b1;
         pos_we  = 1'b1;
      end else if (cmd.commit && replace) begin
         pos_we = 1'b1;
         pos_wa = rd_idx_ff;
         pos_wd = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_wa[AW-1:0]] <= time_wd;
      end
      if (pos_we) begin
         pos_mem[pos_wa[AW-1:0]] <= pos_wd;
      end
      if (rd_en) begin
         rd_time_ff <= time_mem[rd_addr[AW-1:0]];
         rd_pos_ff  <= pos_mem[rd_addr[AW-1:0]];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item || cmd.commit) begin
            rd_vld_ff <= 1'b0;
         end else if (cmd.scan_step || cmd.shift_step) begin
            rd_vld_ff <= rd_en;
         end
         if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff      <= mode;
         key_ff       <= key_time;
         now_ff       <= now_time;
         fwd_ff       <= forward;
         pos_ff       <= position_in;
         idx_ff       <= '0;
         sel_found_ff <= 1'b0;
      end
      if (cmd.scan_step && scan_issue) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.shift_step && shift_issue) begin
         idx_ff <= idx_ff - CNT_W'(1);
      end
      // preceding candidate, and the chosen cue once decided
      if (is_query && rd_vld_ff && (cmd.scan_step || (cmd.commit && pick_cur))) begin
         sel_time_ff  <= rd_time_ff;
         sel_pos_ff   <= rd_pos_ff;
         sel_found_ff <= 1'b1;
      end
      if (cmd.commit) begin
         idx_ff  <= count_ff;
         slot_ff <= hit ? rd_idx_ff : count_ff;
         priority if (is_query) begin
            status_ff <= sicl_pkg::STATUS_ANSWERED;
         end else if (replace) begin
            status_ff <= sicl_pkg::STATUS_REPLACED;
         end else if (full) begin
            status_ff <= sicl_pkg::STATUS_FULL;
         end else begin
            status_ff <= sicl_pkg::STATUS_INSERTED;
         end
      end
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_found_ff  <= sel_found_ff;
         out_time_ff   <= sel_found_ff ? sel_time_ff : '0;
         out_pos_ff    <= sel_found_ff ? sel_pos_ff : '0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign status       = out_status_ff;
   assign found        = out_found_ff;
   assign hit_time     = out_time_ff;
   assign position_out = out_pos_ff;

endmodule

>>> sv/seek_index_cue_lookup_unit.sv
// Seek index cue lookup: keeps up to MAX_CUES cues sorted by time in a single-port-read
// memory and answers insert and seek beats one at a time. Every beat walks the stored
// cues in time order, one memory read per cycle. An insert scans for its slot, then
// moves the later cues up one place through the same read port and writes the new cue,
// then hands off the result. A replacement or a drop on a full table skips the move.
// The next beat is taken in the cycle after the result is loaded. The cue memories have
// no reset and no clearing pass; only entries below the fill count are ever read. A
// finished result sits in an output register, so the next beat is taken while it waits;
// a beat that finishes while that register is still full holds in hand-off until it is
// taken.
module seek_index_cue_lookup_unit #(
   parameter int unsigned MAX_CUES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key_time, play time, forward, position_in, zero pad
   input  logic [sicl_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found, selected cue time, position_out, zero pad
   output logic [sicl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status
   output logic [sicl_pkg::STATUS_W-1:0]       rsp_tuser
);

`include "seek_index_cue_lookup_unit_macros.svh"

   sicl_pkg::cmd_type       cmd;
   sicl_pkg::dp_status_type dp_status;

   logic                        found;
   logic [sicl_pkg::DATA_W-1:0] hit_time;
   logic [sicl_pkg::DATA_W-1:0] position_out;

   logic req_beat;
   logic insert_rsp;
   logic empty_rsp;
   logic no_cue_data;

   sicl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   sicl_dp #(
      .MAX_CUES (MAX_CUES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .dp_status    (dp_status),
      .mode         (req_tuser),
      .key_time     (req_tdata[63:0]),
      .now_time     (req_tdata[127:64]),
      .forward      (req_tdata[128]),
      .position_in  (req_tdata[192:129]),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .status       (rsp_tuser),
      .found        (found),
      .hit_time     (hit_time),
      .position_out (position_out)
   );

   assign rsp_tdata = {{sicl_pkg::RSP_PAD_W{1'b0}}, position_out, hit_time, found};

   assign req_beat    = req_tvalid && req_tready;
   assign insert_rsp  = rsp_tvalid && (rsp_tuser != sicl_pkg::STATUS_ANSWERED);
   assign empty_rsp   = rsp_tvalid && !found;
   assign no_cue_data = (hit_time == '0) && (position_out == '0);

   `SICL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, !req_tready, "beat while busy")
   `SICL_ASSERT_NOW(a_insert_no_cue, clock, reset, insert_rsp, !found, "insert flags a cue")
   `SICL_ASSERT_NOW(a_no_cue_zero, clock, reset, empty_rsp, no_cue_data, "empty result has data")

endmodule

>>> tb/sv/tb_seek_index_cue_lookup_unit.sv
// testbench for the seek index cue lookup unit: directed and random beats against a model
module tb_seek_index_cue_lookup_unit;
   localparam int unsigned MAX_CUES    = 64;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam logic [sicl_pkg::DATA_W-1:0] TOP_TIME = '1;

   typedef struct packed {
      logic [sicl_pkg::STATUS_W-1:0] status;
      logic                          found;
      logic [sicl_pkg::DATA_W-1:0]   stamp;
      logic [sicl_pkg::DATA_W-1:0]   position;
   } cue_answer_type;

   class cue_table_tracker;
      logic [sicl_pkg::DATA_W-1:0] stamps [MAX_CUES];
      logic [sicl_pkg::DATA_W-1:0] cue_pos [MAX_CUES];
      int unsigned       fill;
      cue_answer_type    expected_answers [$];
      int unsigned       errors;
      int unsigned       n_inserted, n_replaced, n_dropped;
      int unsigned       n_found, n_empty, n_forward;

      function new();
         fill = 0;
         errors = 0;
         n_inserted = 0;
         n_replaced = 0;
         n_dropped = 0;
         n_found = 0;
         n_empty = 0;
         n_forward = 0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("error: %s", msg);
      endtask

      function int choose_cue(logic [sicl_pkg::DATA_W-1:0] target,
                              logic [sicl_pkg::DATA_W-1:0] now, logic fwd);
         bit have_prev;
         int prev;
         have_prev = 0;
         prev = 0;
         for (int i = 0; i < fill; i++) begin
            if (stamps[i] == target) begin
               if (!fwd || now < stamps[i]) return i;
            end else if (stamps[i] > target) begin
               if (!have_prev) return i;
               if (!fwd || now < stamps[prev]) return prev;
            end
            have_prev = 1;
            prev = i;
         end
         return have_prev ? prev : -1;
      endfunction

      function void note_request(logic mode, logic [sicl_pkg::DATA_W-1:0] key,
                                 logic [sicl_pkg::DATA_W-1:0] now, logic fwd,
                                 logic [sicl_pkg::DATA_W-1:0] pos);
         cue_answer_type a;
         int unsigned slot;
         int pick;
         a = '0;
         if (mode == sicl_pkg::MODE_INSERT) begin
            slot = 0;
            while (slot < fill && stamps[slot] < key) slot++;
            if (slot < fill && stamps[slot] == key) begin
               cue_pos[slot] = pos;
               a.status = sicl_pkg::STATUS_REPLACED;
               n_replaced++;
            end else if (fill >= MAX_CUES) begin
               a.status = sicl_pkg::STATUS_FULL;
               n_dropped++;
            end else begin
               for (int j = fill; j > slot; j--) begin
                  stamps[j] = stamps[j-1];
                  cue_pos[j] = cue_pos[j-1];
               end
               stamps[slot] = key;
               cue_pos[slot] = pos;
               fill++;
               a.status = sicl_pkg::STATUS_INSERTED;
               n_inserted++;
            end
         end else begin
            pick = choose_cue(key, now, fwd);
            a.status = sicl_pkg::STATUS_ANSWERED;
            if (fwd) n_forward++;
            if (pick >= 0) begin
               a.found = 1'b1;
               a.stamp = stamps[pick];
               a.position = cue_pos[pick];
               n_found++;
            end else begin
               n_empty++;
            end
         end
         expected_answers.push_back(a);
      endfunction

      task check_response(cue_answer_type got);
         cue_answer_type exp;
         if (expected_answers.size() == 0) begin
            report($sformatf("unexpected result beat status %0d", got.status));
         end else begin
            exp = expected_answers.pop_front();
            if (got.status !== exp.status)
               report($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.found !== exp.found)
               report($sformatf("found %0d, want %0d", got.found, exp.found));
            if (got.stamp !== exp.stamp)
               report($sformatf("cue time %h, want %h", got.stamp, exp.stamp));
            if (got.position !== exp.position)
               report($sformatf("position %h, want %h", got.position, exp.position));
         end
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [sicl_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [sicl_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic [sicl_pkg::STATUS_W-1:0]     rsp_tuser;

   cue_table_tracker cues = new();
   bit          no_idle = 0;
   int unsigned cycles = 0;

   seek_index_cue_lookup_unit #(.MAX_CUES(MAX_CUES)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || ($urandom_range(0, 99) >= 31);
   end

   always @(posedge clock) begin
      cue_answer_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.found = rsp_tdata[0];
         got.stamp = rsp_tdata[sicl_pkg::DATA_W:1];
         got.position = rsp_tdata[2*sicl_pkg::DATA_W:sicl_pkg::DATA_W+1];
         cues.check_response(got);
      end
   end

   task send_item(logic mode, logic [sicl_pkg::DATA_W-1:0] key,
                  logic [sicl_pkg::DATA_W-1:0] now, logic fwd,
                  logic [sicl_pkg::DATA_W-1:0] pos);
      while (!no_idle && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(sicl_pkg::REQ_TDATA_W - 3*sicl_pkg::DATA_W - 1){1'b0}},
                    pos, fwd, now, key};
      do @(posedge clock); while (!req_tready);
      cues.note_request(mode, key, now, fwd, pos);
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (cues.expected_answers.size() != 0) @(posedge clock);
   endtask

   function logic [sicl_pkg::DATA_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   function logic [sicl_pkg::DATA_W-1:0] edge_time();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 64'd1;
         2: return TOP_TIME - 1;
         default: return TOP_TIME;
      endcase
   endfunction

   function logic [sicl_pkg::DATA_W-1:0] near_stored(logic [sicl_pkg::DATA_W-1:0] fallback);
      logic [sicl_pkg::DATA_W-1:0] base;
      base = (cues.fill > 0) ? cues.stamps[$urandom_range(0, cues.fill - 1)] : fallback;
      case ($urandom_range(0, 2))
         0: return base;
         1: return base + $urandom_range(1, 3);
         default: return base - $urandom_range(1, 3);
      endcase
   endfunction

   function logic [sicl_pkg::DATA_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55 && cues.fill > 0) return near_stored(64'd0);
      if (r < 65) return edge_time();
      if (r < 80) return 64'd1000 * $urandom_range(0, 200);
      return wide_random();
   endfunction

   function logic [sicl_pkg::DATA_W-1:0] pick_now(logic [sicl_pkg::DATA_W-1:0] key);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return near_stored(key);
      if (r < 60) return key + $urandom_range(0, 4) - 2;
      if (r < 70) return edge_time();
      return wide_random();
   endfunction

   task random_item();
      logic mode;
      logic [sicl_pkg::DATA_W-1:0] key;
      mode = ($urandom_range(0, 99) < 45) ? sicl_pkg::MODE_INSERT : sicl_pkg::MODE_QUERY;
      key = pick_key();
      send_item(mode, key, pick_now(key), 1'($urandom_range(0, 1)), wide_random());
   endtask

   initial begin
      logic [sicl_pkg::DATA_W-1:0] key;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table queries
      send_item(sicl_pkg::MODE_QUERY, 64'd0, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_QUERY, TOP_TIME, TOP_TIME, 1'b1, TOP_TIME);
      send_item(sicl_pkg::MODE_INSERT, 64'd1000, 64'd0, 1'b0, 64'h0123_4567_89ab_cdef);
      // target before the first cue, forward does not apply
      send_item(sicl_pkg::MODE_QUERY, 64'd10, TOP_TIME, 1'b1, '0);
      send_item(sicl_pkg::MODE_INSERT, 64'd0, TOP_TIME, 1'b1, TOP_TIME);
      send_item(sicl_pkg::MODE_INSERT, TOP_TIME, 64'd0, 1'b0, 64'd0);
      send_item(sicl_pkg::MODE_INSERT, 64'd500, 64'd0, 1'b0, 64'h5555_aaaa_5555_aaaa);
      send_item(sicl_pkg::MODE_INSERT, 64'd1000, 64'd0, 1'b0, 64'hfedc_ba98_7654_3210);
      send_item(sicl_pkg::MODE_QUERY, 64'd500, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_QUERY, 64'd700, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_QUERY, 64'd0, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_QUERY, 64'd0, 64'd5, 1'b1, '0);
      // no candidate after play time
      send_item(sicl_pkg::MODE_QUERY, 64'd700, TOP_TIME, 1'b1, '0);
      send_item(sicl_pkg::MODE_QUERY, 64'd700, 64'd100, 1'b1, '0);
      send_item(sicl_pkg::MODE_QUERY, TOP_TIME, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_QUERY, TOP_TIME, TOP_TIME, 1'b1, '0);
      send_item(sicl_pkg::MODE_QUERY, TOP_TIME - 1, 64'd0, 1'b0, '0);
      send_item(sicl_pkg::MODE_INSERT, TOP_TIME, 64'd0, 1'b0, 64'haaaa_5555_aaaa_5555);
      send_item(sicl_pkg::MODE_QUERY, 64'd999, 64'd999, 1'b1, '0);
      send_item(sicl_pkg::MODE_QUERY, 64'd1001, 64'd1000, 1'b1, '0);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 250 && n < 350);
         random_item();
         if ($urandom_range(0, 99) < 2) wait_drained();
      end
      no_idle = 0;
      wait_drained();

      // fill up, then drops and replacements on a full table, mixed with queries
      while (cues.fill < MAX_CUES)
         send_item(sicl_pkg::MODE_INSERT, wide_random(), wide_random(), 1'b0, wide_random());
      for (int n = 0; n < 12; n++) begin
         key = ($urandom_range(0, 1) == 0) ? wide_random() : near_stored(64'd0);
         send_item(sicl_pkg::MODE_INSERT, key, wide_random(), 1'b0, wide_random());
         key = pick_key();
         send_item(sicl_pkg::MODE_QUERY, key, pick_now(key), 1'($urandom_range(0, 1)),
                   wide_random());
      end

      wait_drained();
      repeat (4 * MAX_CUES + 20) @(posedge clock);
      while (cues.expected_answers.size() != 0) begin
         void'(cues.expected_answers.pop_front());
         cues.report("expected result never arrived");
      end
      $display("covered: %0d inserts, %0d replacements, %0d drops on a full table",
               cues.n_inserted, cues.n_replaced, cues.n_dropped);
      $display("covered: %0d queries answered, %0d on an empty table, %0d forward",
               cues.n_found, cues.n_empty, cues.n_forward);
      if (cues.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
